// ===== rtl/ddm_pkg.sv =====
package ddm_pkg;

    localparam int unsigned PULSE_W    = 12;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned LIMIT_W    = 11;
    localparam int unsigned RATE_W     = 8;
    localparam int unsigned DRIVE_W    = 16;
    localparam int unsigned DEV_W      = 14;
    localparam int unsigned PROD_W     = LIMIT_W + RATE_W;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef logic signed [DEV_W-1:0] dev_t;

    localparam dev_t CENTER = 14'sd1500;

    localparam logic [PULSE_W-1:0] ARM_LEVEL_RST    = 12'd1800;
    localparam logic [PULSE_W-1:0] DISARM_LEVEL_RST = 12'd1200;
    localparam logic [TIME_W-1:0]  ARM_HOLD_RST     = 32'd3000000;
    localparam logic [TIME_W-1:0]  DISARM_HOLD_RST  = 32'd3000;
    localparam logic [LIMIT_W-1:0] TURN_LIMIT_RST   = 11'd350;
    localparam logic [LIMIT_W-1:0] LEFT_LIMIT_RST   = 11'd500;
    localparam logic [LIMIT_W-1:0] RIGHT_LIMIT_RST  = 11'd1500;
    localparam logic [RATE_W-1:0]  DRIVE_RATE_RST   = 8'd35;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARM_LEVEL    = 3'd0,
        CFG_DISARM_LEVEL = 3'd1,
        CFG_ARM_HOLD     = 3'd2,
        CFG_DISARM_HOLD  = 3'd3,
        CFG_TURN_LIMIT   = 3'd4,
        CFG_LEFT_LIMIT   = 3'd5,
        CFG_RIGHT_LIMIT  = 3'd6,
        CFG_DRIVE_RATE   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] fwd;
        logic [DRIVE_W-1:0] rev;
    } side_drive_t;

endpackage

// ===== rtl/ddm_side.sv =====
module ddm_side (
    input  ddm_pkg::dev_t                      dev,
    input  logic [ddm_pkg::LIMIT_W-1:0]        limit,
    input  logic [ddm_pkg::RATE_W-1:0]         rate,
    output ddm_pkg::side_drive_t               drive
);

    ddm_pkg::dev_t                      lim_s;
    logic                               pos;
    ddm_pkg::dev_t                      mag_s;
    logic [ddm_pkg::LIMIT_W-1:0]        mag;
    logic [ddm_pkg::PROD_W-1:0]         prod;
    logic [ddm_pkg::DRIVE_W-1:0]        sat;

    assign lim_s = $signed({{(ddm_pkg::DEV_W - ddm_pkg::LIMIT_W){1'b0}}, limit});
    assign pos   = (dev > 0);

    always_comb begin
        if (pos) begin
            mag_s = (dev > lim_s) ? lim_s : dev;
        end else begin
            mag_s = (dev < -lim_s) ? lim_s : -dev;
        end
    end

    assign mag  = mag_s[ddm_pkg::LIMIT_W-1:0];
    assign prod = ddm_pkg::PROD_W'(mag) * ddm_pkg::PROD_W'(rate);
    assign sat  = (|prod[ddm_pkg::PROD_W-1:ddm_pkg::DRIVE_W]) ? {ddm_pkg::DRIVE_W{1'b1}}
                                                              : prod[ddm_pkg::DRIVE_W-1:0];

    assign drive.fwd = pos ? sat : '0;
    assign drive.rev = pos ? '0 : sat;

endmodule

// ===== rtl/diff_drive_mixer_with_arming_core.sv =====
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_valid / s_ready  | turn, throttle, lock pulse, now_us
// m_       | out       | m_valid / m_ready  | left/right forward/reverse, is_armed
// cfg_     | in        | cfg_wr_en          | cfg_index, cfg_data
//
// One beat per cycle sustained while m_ready holds high; a beat passes the input register, then the result register.
// Input register, then arming update and mixing in one pass into the result register.
// Arm state and hold mark advance when a beat moves into the result register.
// Synchronous active-low reset clears valids, arm state and hold mark, and loads config defaults.
// A stalled result holds; the input register still fills, so one beat waits behind it.
module diff_drive_mixer_with_arming_core (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [ddm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ddm_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ddm_pkg::PULSE_W-1:0]         s_turn_pulse,
    input  logic [ddm_pkg::PULSE_W-1:0]         s_throttle_pulse,
    input  logic [ddm_pkg::PULSE_W-1:0]         s_lock_pulse,
    input  logic [ddm_pkg::TIME_W-1:0]          s_now_us,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ddm_pkg::DRIVE_W-1:0]         m_left_forward,
    output logic [ddm_pkg::DRIVE_W-1:0]         m_left_reverse,
    output logic [ddm_pkg::DRIVE_W-1:0]         m_right_forward,
    output logic [ddm_pkg::DRIVE_W-1:0]         m_right_reverse,
    output logic                                m_is_armed
);

    logic [ddm_pkg::PULSE_W-1:0]  arm_level_reg;
    logic [ddm_pkg::PULSE_W-1:0]  disarm_level_reg;
    logic [ddm_pkg::TIME_W-1:0]   arm_hold_reg;
    logic [ddm_pkg::TIME_W-1:0]   disarm_hold_reg;
    logic [ddm_pkg::LIMIT_W-1:0]  turn_limit_reg;
    logic [ddm_pkg::LIMIT_W-1:0]  left_limit_reg;
    logic [ddm_pkg::LIMIT_W-1:0]  right_limit_reg;
    logic [ddm_pkg::RATE_W-1:0]   drive_rate_reg;

    logic                         in_valid_reg;
    logic [ddm_pkg::PULSE_W-1:0]  turn_reg;
    logic [ddm_pkg::PULSE_W-1:0]  throttle_reg;
    logic [ddm_pkg::PULSE_W-1:0]  lock_reg;
    logic [ddm_pkg::TIME_W-1:0]   now_reg;

    logic                         armed_reg;
    logic                         armed_next;
    logic [ddm_pkg::TIME_W-1:0]   hold_mark_reg;
    logic [ddm_pkg::TIME_W-1:0]   hold_mark_next;

    logic                         out_valid_reg;
    ddm_pkg::side_drive_t         left_reg;
    ddm_pkg::side_drive_t         right_reg;
    logic                         is_armed_reg;

    logic                         advance;
    logic                         step;
    logic                         active;
    logic [ddm_pkg::TIME_W-1:0]   hold;
    logic [ddm_pkg::TIME_W-1:0]   elapsed;

    ddm_pkg::dev_t                turn_off;
    ddm_pkg::dev_t                turn_lim;
    ddm_pkg::dev_t                offset;
    ddm_pkg::dev_t                thr_c;
    ddm_pkg::dev_t                left_dev;
    ddm_pkg::dev_t                right_dev;
    ddm_pkg::side_drive_t         left_drive;
    ddm_pkg::side_drive_t         right_drive;

    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_level_reg    <= ddm_pkg::ARM_LEVEL_RST;
            disarm_level_reg <= ddm_pkg::DISARM_LEVEL_RST;
            arm_hold_reg     <= ddm_pkg::ARM_HOLD_RST;
            disarm_hold_reg  <= ddm_pkg::DISARM_HOLD_RST;
            turn_limit_reg   <= ddm_pkg::TURN_LIMIT_RST;
            left_limit_reg   <= ddm_pkg::LEFT_LIMIT_RST;
            right_limit_reg  <= ddm_pkg::RIGHT_LIMIT_RST;
            drive_rate_reg   <= ddm_pkg::DRIVE_RATE_RST;
        end else if (cfg_wr_en) begin
            unique case (ddm_pkg::cfg_idx_t'(cfg_index))
                ddm_pkg::CFG_ARM_LEVEL:    arm_level_reg    <= cfg_data[ddm_pkg::PULSE_W-1:0];
                ddm_pkg::CFG_DISARM_LEVEL: disarm_level_reg <= cfg_data[ddm_pkg::PULSE_W-1:0];
                ddm_pkg::CFG_ARM_HOLD:     arm_hold_reg     <= cfg_data[ddm_pkg::TIME_W-1:0];
                ddm_pkg::CFG_DISARM_HOLD:  disarm_hold_reg  <= cfg_data[ddm_pkg::TIME_W-1:0];
                ddm_pkg::CFG_TURN_LIMIT:   turn_limit_reg   <= cfg_data[ddm_pkg::LIMIT_W-1:0];
                ddm_pkg::CFG_LEFT_LIMIT:   left_limit_reg   <= cfg_data[ddm_pkg::LIMIT_W-1:0];
                ddm_pkg::CFG_RIGHT_LIMIT:  right_limit_reg  <= cfg_data[ddm_pkg::LIMIT_W-1:0];
                ddm_pkg::CFG_DRIVE_RATE:   drive_rate_reg   <= cfg_data[ddm_pkg::RATE_W-1:0];
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            turn_reg     <= s_turn_pulse;
            throttle_reg <= s_throttle_pulse;
            lock_reg     <= s_lock_pulse;
            now_reg      <= s_now_us;
        end
    end

    // arming
    always_comb begin
        if (!armed_reg) begin
            active = (lock_reg > arm_level_reg);
            hold   = arm_hold_reg;
        end else begin
            active = (lock_reg < disarm_level_reg);
            hold   = disarm_hold_reg;
        end
        elapsed        = now_reg - hold_mark_reg;
        armed_next     = armed_reg;
        hold_mark_next = hold_mark_reg;
        if (active) begin
            if (elapsed > hold) begin
                hold_mark_next = now_reg;
                armed_next     = !armed_reg;
            end
        end else begin
            hold_mark_next = now_reg;
        end
    end

    // mixer
    always_comb begin
        turn_off = $signed({{(ddm_pkg::DEV_W - ddm_pkg::PULSE_W){1'b0}}, turn_reg})
                   - ddm_pkg::CENTER;
        turn_lim = $signed({{(ddm_pkg::DEV_W - ddm_pkg::LIMIT_W){1'b0}}, turn_limit_reg});
        if (turn_off > turn_lim) begin
            offset = turn_lim;
        end else if (turn_off < -turn_lim) begin
            offset = -turn_lim;
        end else begin
            offset = turn_off;
        end
        thr_c     = $signed({{(ddm_pkg::DEV_W - ddm_pkg::PULSE_W){1'b0}}, throttle_reg})
                    - ddm_pkg::CENTER;
        left_dev  = thr_c + offset;
        right_dev = thr_c - offset;
    end

    ddm_side u_left (
        .dev   (left_dev),
        .limit (left_limit_reg),
        .rate  (drive_rate_reg),
        .drive (left_drive)
    );

    ddm_side u_right (
        .dev   (right_dev),
        .limit (right_limit_reg),
        .rate  (drive_rate_reg),
        .drive (right_drive)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg     <= 1'b0;
            hold_mark_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                armed_reg     <= armed_next;
                hold_mark_reg <= hold_mark_next;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // result register; zero drive when disarmed
    always_ff @(posedge aclk) begin
        if (step) begin
            left_reg     <= armed_next ? left_drive  : '0;
            right_reg    <= armed_next ? right_drive : '0;
            is_armed_reg <= armed_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_left_forward  = left_reg.fwd;
    assign m_left_reverse  = left_reg.rev;
    assign m_right_forward = right_reg.fwd;
    assign m_right_reverse = right_reg.rev;
    assign m_is_armed      = is_armed_reg;

endmodule
